/* design/hbs_pkg.sv */
package hbs_pkg;

  // Fixed field widths of the request and result ports.
  localparam int CELL_W     = 6;
  localparam int HT_W       = 5;
  localparam int POS_W      = 16;
  localparam int OUT_W      = 32;
  localparam int THR_W      = 5;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Grid coordinates cover grids of up to 256 cells per axis.
  localparam int COORD_W = 8;

  // Signed offset from the clamped cell in fraction units; one extra bit of headroom.
  localparam int OFF_W = 17;

  // Blend datapath widths, sized for the largest fraction width supported.
  localparam int PX_W  = 23;   // height step times offset
  localparam int A_W   = 24;   // blend along x
  localparam int DA_W  = 25;   // difference of the two x blends
  localparam int H_W   = 42;   // full bilinear sum in height steps
  localparam int HLO_W = 21;   // low slice of the sum for the split scale product
  localparam int PLO_W = SCALE_W + HLO_W;
  localparam int PHI_W = SCALE_W + 1 + H_W - HLO_W;
  localparam int N_W   = 60;   // scaled sum before rounding

  // Command queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]   THR_RESET   = 5'd4;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6554;

  // Saturation limits of the result.
  localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } hbs_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIFF_THRESHOLD = 1'b0,
    CFG_HEIGHT_SCALE    = 1'b1
  } hbs_cfg_idx_t;

  // One classified request as it travels from front to back end.
  typedef struct packed {
    hbs_kind_t                 kind;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        z;
    logic signed [HT_W-1:0]    height;
    logic signed [OFF_W-1:0]   tx;
    logic signed [OFF_W-1:0]   tz;
  } hbs_cmd_t;

  // Fill state of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } hbs_q_status_t;

endpackage

/* design/heightmap_bilinear_sampler_unit.sv */
// Channel   Ports                                        Handshake
// request   start, busy, in_kind .. in_pos_z             taken when start and not busy
// result    out_valid, out_height, out_plateau           one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    written when valid and ready
//
// A write request is carried out as it leaves the queue; a sample request holds the back end through
// four reads of the single-port grid memory, a cliff check and three blend steps.
// The result appears on the cycle after the last blend step. A two-entry command
// queue decouples the front end, so busy rises only while that queue is full.
// Reset loads the register defaults and empties the queue; grid cells hold no value
// until written. The receiver cannot stall results.
module heightmap_bilinear_sampler_unit #(
  parameter int GRID_WIDTH = 64,
  parameter int GRID_DEPTH = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_kind,
  input  logic [hbs_pkg::CELL_W-1:0]             in_cell_x,
  input  logic [hbs_pkg::CELL_W-1:0]             in_cell_z,
  input  logic signed [hbs_pkg::HT_W-1:0]        in_cell_height,
  input  logic signed [hbs_pkg::POS_W-1:0]       in_pos_x,
  input  logic signed [hbs_pkg::POS_W-1:0]       in_pos_z,
  output logic                                   out_valid,
  output logic signed [hbs_pkg::OUT_W-1:0]       out_height,
  output logic                                   out_plateau,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import hbs_pkg::*;

  logic [THR_W-1:0]   cliff_threshold_r;
  logic [SCALE_W-1:0] height_scale_r;
  hbs_q_status_t      q_status;
  hbs_cmd_t           push_cmd;
  hbs_cmd_t           head;
  logic               push;
  logic               pop;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cliff_threshold_r <= THR_RESET;
      height_scale_r    <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hbs_cfg_idx_t'(cfg_index))
        CFG_CLIFF_THRESHOLD: cliff_threshold_r <= cfg_data[THR_W-1:0];
        CFG_HEIGHT_SCALE:    height_scale_r    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accepts and classifies requests.
  hbs_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_DEPTH (GRID_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .start          (start),
    .in_kind        (in_kind),
    .in_cell_x      (in_cell_x),
    .in_cell_z      (in_cell_z),
    .in_cell_height (in_cell_height),
    .in_pos_x       (in_pos_x),
    .in_pos_z       (in_pos_z),
    .q_status       (q_status),
    .busy           (busy),
    .push           (push),
    .cmd            (push_cmd)
  );

  // Command queue between the two halves.
  hbs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: grid memory, corner reads and blend.
  hbs_back #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_DEPTH (GRID_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .cliff_threshold (cliff_threshold_r),
    .height_scale    (height_scale_r),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_height      (out_height),
    .out_plateau     (out_plateau)
  );

endmodule

/* design/hbs_front.sv */
module hbs_front #(
  parameter int GRID_WIDTH = 64,
  parameter int GRID_DEPTH = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 start,
  input  logic                                 in_kind,
  input  logic [hbs_pkg::CELL_W-1:0]           in_cell_x,
  input  logic [hbs_pkg::CELL_W-1:0]           in_cell_z,
  input  logic signed [hbs_pkg::HT_W-1:0]      in_cell_height,
  input  logic signed [hbs_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [hbs_pkg::POS_W-1:0]     in_pos_z,
  input  hbs_pkg::hbs_q_status_t               q_status,
  output logic                                 busy,
  output logic                                 push,
  output hbs_pkg::hbs_cmd_t                    cmd
);
  import hbs_pkg::*;

  localparam logic signed [16:0] X_HI = 17'(GRID_WIDTH - 2);
  localparam logic signed [16:0] Z_HI = 17'(GRID_DEPTH - 2);

  logic               accept;
  logic               write_in_grid;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] z0;

  // Floor of the position, clamped to the range 0 .. hi.
  function automatic logic [COORD_W-1:0] base_cell(input logic signed [POS_W-1:0] p,
                                                   input logic signed [16:0] hi);
    logic signed [16:0] c;
    c = 17'(p >>> FRAC_BITS);
    if (c < 0) begin
      return '0;
    end else if (c > hi) begin
      return hi[COORD_W-1:0];
    end
    return c[COORD_W-1:0];
  endfunction

  // Signed offset of the position from the clamped cell, in fraction units.
  function automatic logic signed [OFF_W-1:0] cell_offset(input logic signed [POS_W-1:0] p,
                                                          input logic [COORD_W-1:0] c);
    logic [17:0]        cs;
    logic signed [17:0] t;
    cs = 18'(c) << FRAC_BITS;
    t  = 18'(p) - signed'(cs);
    return t[OFF_W-1:0];
  endfunction

  // A request is taken whenever the queue has room.
  assign busy   = q_status.full;
  assign accept = start && !busy;

  // Writes outside the grid are dropped here and never reach the back end.
  assign write_in_grid = (9'(in_cell_x) < 9'(GRID_WIDTH)) && (9'(in_cell_z) < 9'(GRID_DEPTH));
  assign push = accept && ((in_kind == KIND_SAMPLE) || write_in_grid);

  assign x0 = base_cell(in_pos_x, X_HI);
  assign z0 = base_cell(in_pos_z, Z_HI);

  // Build the queued command for either kind of request.
  always_comb begin
    cmd.kind   = hbs_kind_t'(in_kind);
    cmd.height = in_cell_height;
    if (in_kind == KIND_SAMPLE) begin
      cmd.x  = x0;
      cmd.z  = z0;
      cmd.tx = cell_offset(in_pos_x, x0);
      cmd.tz = cell_offset(in_pos_z, z0);
    end else begin
      cmd.x  = COORD_W'(in_cell_x);
      cmd.z  = COORD_W'(in_cell_z);
      cmd.tx = '0;
      cmd.tz = '0;
    end
  end

endmodule

/* design/hbs_cmd_fifo.sv */
module hbs_cmd_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  hbs_pkg::hbs_cmd_t       push_cmd,
  input  logic                    pop,
  output hbs_pkg::hbs_cmd_t       head,
  output hbs_pkg::hbs_q_status_t  status
);
  import hbs_pkg::*;

  hbs_cmd_t             entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic [Q_CNT_W-1:0]   count_nxt;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = entries_r[rd_ptr_r];

  // Occupancy follows pushes and pops; both may happen in one cycle.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/hbs_back.sv */
module hbs_back #(
  parameter int GRID_WIDTH = 64,
  parameter int GRID_DEPTH = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hbs_pkg::hbs_cmd_t                   head,
  input  hbs_pkg::hbs_q_status_t              q_status,
  input  logic [hbs_pkg::THR_W-1:0]           cliff_threshold,
  input  logic [hbs_pkg::SCALE_W-1:0]         height_scale,
  output logic                                pop,
  output logic                                out_valid,
  output logic signed [hbs_pkg::OUT_W-1:0]    out_height,
  output logic                                out_plateau
);
  import hbs_pkg::*;

  localparam int MEM_DEPTH = GRID_WIDTH * GRID_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int RES_W     = N_W - 2 * FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_C1,
    S_C2,
    S_C3,
    S_CHK,
    S_BL1,
    S_BL2,
    S_BL3
  } state_t;

  state_t                     state_r;
  state_t                     state_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [OUT_W-1:0]           out_height_r;
  logic [OUT_W-1:0]           out_height_nxt;
  logic                       out_plateau_r;

  // Grid memory, single port.
  logic signed [HT_W-1:0]     mem [MEM_DEPTH];
  logic [ADDR_W-1:0]          mem_addr;
  logic                       mem_we;
  logic signed [HT_W-1:0]     rdata_r;

  // Datapath registers.
  logic [ADDR_W-1:0]          base_r;
  logic signed [OFF_W-1:0]    tx_r;
  logic signed [OFF_W-1:0]    tz_r;
  logic signed [HT_W-1:0]     h00_r;
  logic signed [HT_W-1:0]     h10_r;
  logic signed [HT_W-1:0]     h01_r;
  logic                       plat_r;
  logic                       plat_nxt;
  logic signed [A_W-1:0]      a0_r;
  logic signed [A_W-1:0]      a0_nxt;
  logic signed [A_W-1:0]      a1_r;
  logic signed [A_W-1:0]      a1_nxt;
  logic signed [H_W-1:0]      h_r;
  logic signed [H_W-1:0]      h_nxt;
  logic [PLO_W-1:0]           plo_r;
  logic [PLO_W-1:0]           plo_nxt;
  logic signed [PHI_W-1:0]    phi_r;
  logic signed [PHI_W-1:0]    phi_nxt;

  // Intermediate terms.
  logic [5:0]                 step_max;
  logic signed [5:0]          dx0;
  logic signed [5:0]          dx1;
  logic signed [PX_W-1:0]     px0;
  logic signed [PX_W-1:0]     px1;
  logic signed [DA_W-1:0]     da;
  logic signed [H_W-1:0]      pz;
  logic signed [N_W-1:0]      n_sum;
  logic [RES_W-1:0]           res;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] z);
    logic [16:0] lin;
    lin = 17'(z) * 17'(GRID_WIDTH) + 17'(x);
    return lin[ADDR_W-1:0];
  endfunction

  function automatic logic [5:0] absdiff(input logic signed [HT_W-1:0] a,
                                         input logic signed [HT_W-1:0] b);
    logic signed [5:0] d;
    d = 6'(a) - 6'(b);
    return (d < 0) ? 6'(-d) : 6'(d);
  endfunction

  assign pop = (state_r == S_IDLE) && !q_status.empty;

  // Memory address: the request's cell when idle, then the remaining three corners.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = base_r;
    case (state_r)
      S_IDLE: begin
        mem_addr = cell_addr(head.x, head.z);
        mem_we   = pop && (head.kind == KIND_WRITE);
      end
      S_C1:    mem_addr = base_r + ADDR_W'(1);
      S_C2:    mem_addr = base_r + ADDR_W'(GRID_WIDTH);
      S_C3:    mem_addr = base_r + ADDR_W'(GRID_WIDTH + 1);
      default: mem_addr = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head.height;
    end
    rdata_r <= mem[mem_addr];
  end

  // Cliff test over every side of the cell; the last corner comes straight from memory.
  always_comb begin
    step_max = absdiff(h00_r, h10_r);
    if (absdiff(h10_r, rdata_r) > step_max) begin
      step_max = absdiff(h10_r, rdata_r);
    end
    if (absdiff(rdata_r, h01_r) > step_max) begin
      step_max = absdiff(rdata_r, h01_r);
    end
    if (absdiff(h01_r, h00_r) > step_max) begin
      step_max = absdiff(h01_r, h00_r);
    end
    plat_nxt = (step_max >= 6'(cliff_threshold));
  end

  // Blend along x; on a cliff both rows collapse to the h00 corner.
  always_comb begin
    dx0 = 6'(h10_r) - 6'(h00_r);
    dx1 = 6'(rdata_r) - 6'(h01_r);
    px0 = dx0 * tx_r;
    px1 = dx1 * tx_r;
    if (plat_nxt) begin
      a0_nxt = A_W'(h00_r) <<< FRAC_BITS;
      a1_nxt = A_W'(h00_r) <<< FRAC_BITS;
    end else begin
      a0_nxt = (A_W'(h00_r) <<< FRAC_BITS) + A_W'(px0);
      a1_nxt = (A_W'(h01_r) <<< FRAC_BITS) + A_W'(px1);
    end
  end

  // Blend along z.
  always_comb begin
    da    = DA_W'(a1_r) - DA_W'(a0_r);
    pz    = da * tz_r;
    h_nxt = (H_W'(a0_r) <<< FRAC_BITS) + pz;
  end

  // Scale by the height factor in two partial products.
  always_comb begin
    plo_nxt = height_scale * h_r[HLO_W-1:0];
    phi_nxt = $signed({1'b0, height_scale}) * $signed(h_r[H_W-1:HLO_W]);
  end

  // Recombine, round half up, drop the fraction and saturate.
  always_comb begin
    n_sum = (N_W'(phi_r) <<< HLO_W) + $signed(N_W'(plo_r))
          + (N_W'(1) <<< (2 * FRAC_BITS - 1));
    res   = n_sum[N_W-1:2*FRAC_BITS];
    if ((&res[RES_W-1:OUT_W-1]) || !(|res[RES_W-1:OUT_W-1])) begin
      out_height_nxt = res[OUT_W-1:0];
    end else if (res[RES_W-1]) begin
      out_height_nxt = SAT_MIN;
    end else begin
      out_height_nxt = SAT_MAX;
    end
  end

  // Sequencer: four corner reads, cliff test, three blend steps.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop && (head.kind == KIND_SAMPLE)) begin
          state_nxt = S_C1;
        end
      end
      S_C1:  state_nxt = S_C2;
      S_C2:  state_nxt = S_C3;
      S_C3:  state_nxt = S_CHK;
      S_CHK: state_nxt = S_BL1;
      S_BL1: state_nxt = S_BL2;
      S_BL2: state_nxt = S_BL3;
      S_BL3: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      out_height_r  <= '0;
      out_plateau_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_BL3) begin
        out_height_r  <= out_height_nxt;
        out_plateau_r <= plat_r;
      end
    end
  end

  // Datapath registers, loaded in the step that produces them.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        base_r <= cell_addr(head.x, head.z);
        tx_r   <= head.tx;
        tz_r   <= head.tz;
      end
      S_C1: h00_r <= rdata_r;
      S_C2: h10_r <= rdata_r;
      S_C3: h01_r <= rdata_r;
      S_CHK: begin
        plat_r <= plat_nxt;
        a0_r   <= a0_nxt;
        a1_r   <= a1_nxt;
      end
      S_BL1: h_r <= h_nxt;
      S_BL2: begin
        plo_r <= plo_nxt;
        phi_r <= phi_nxt;
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_plateau = out_plateau_r;

endmodule

/* sim/tb_heightmap_bilinear_sampler_unit.sv */
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler_unit;
  import hbs_pkg::*;

  localparam int GRID_W        = 64;
  localparam int GRID_D        = 64;
  localparam int FRAC          = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int PHASES        = 5;
  localparam int MAX_REPORTS   = 10;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // One predicted sample result.
  typedef struct {
    logic signed [OUT_W-1:0] height;
    logic                    plateau;
  } height_result_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic                         in_kind        = 1'b0;
  logic [CELL_W-1:0]            in_cell_x      = '0;
  logic [CELL_W-1:0]            in_cell_z      = '0;
  logic signed [HT_W-1:0]       in_cell_height = '0;
  logic signed [POS_W-1:0]      in_pos_x       = '0;
  logic signed [POS_W-1:0]      in_pos_z       = '0;
  logic                         out_valid;
  logic signed [OUT_W-1:0]      out_height;
  logic                         out_plateau;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index      = '0;
  logic [CFG_DATA_W-1:0]        cfg_data       = '0;

  // Shadow copy of the grid and the registers.
  logic signed [HT_W-1:0] grid_heights [GRID_W*GRID_D];
  bit                     cell_loaded  [GRID_W*GRID_D];
  logic [THR_W-1:0]       cliff_thr;
  logic [SCALE_W-1:0]     height_scale;

  height_result_t expected_heights [$];
  int     error_count = 0;
  int     sent_items  = 0;
  int     burst_left  = 0;
  int     band_lo;
  int     band_w;
  longint cycle_count = 0;

  heightmap_bilinear_sampler_unit #(
    .GRID_WIDTH(GRID_W),
    .GRID_DEPTH(GRID_D),
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_cell_x     (in_cell_x),
    .in_cell_z     (in_cell_z),
    .in_cell_height(in_cell_height),
    .in_pos_x      (in_pos_x),
    .in_pos_z      (in_pos_z),
    .out_valid     (out_valid),
    .out_height    (out_height),
    .out_plateau   (out_plateau),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Floor of the position, clamped so that the cell and its far neighbour lie in the grid.
  function automatic longint base_cell(logic signed [POS_W-1:0] pos, int size);
    longint c;
    c = longint'(pos) >>> FRAC;
    if (c < 0) c = 0;
    if (c > size - 2) c = size - 2;
    return c;
  endfunction

  function automatic longint abs_step(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected height and plateau flag for a sample at (px, pz).
  function automatic height_result_t predict_height(logic signed [POS_W-1:0] px,
                                                    logic signed [POS_W-1:0] pz);
    longint x0, z0, tx, tz, one;
    longint h00, h10, h01, h11, worst, sc;
    longint y00, y10, y01, y11, a0, a1, n, res;
    height_result_t r;
    x0  = base_cell(px, GRID_W);
    z0  = base_cell(pz, GRID_D);
    one = longint'(1) << FRAC;
    tx  = longint'(px) - x0 * one;
    tz  = longint'(pz) - z0 * one;
    h00 = longint'(grid_heights[z0 * GRID_W + x0]);
    h10 = longint'(grid_heights[z0 * GRID_W + x0 + 1]);
    h01 = longint'(grid_heights[(z0 + 1) * GRID_W + x0]);
    h11 = longint'(grid_heights[(z0 + 1) * GRID_W + x0 + 1]);

    // Largest step around the rim of the cell.
    worst = abs_step(h00, h10);
    if (abs_step(h10, h11) > worst) worst = abs_step(h10, h11);
    if (abs_step(h11, h01) > worst) worst = abs_step(h11, h01);
    if (abs_step(h01, h00) > worst) worst = abs_step(h01, h00);

    sc  = longint'(height_scale);
    y00 = h00 * sc;
    y10 = h10 * sc;
    y01 = h01 * sc;
    y11 = h11 * sc;

    if (worst >= longint'(cliff_thr)) begin
      res       = y00;
      r.plateau = 1'b1;
    end else begin
      // Exact blend, then round to nearest with ties going up.
      a0  = y00 * one + (y10 - y00) * tx;
      a1  = y01 * one + (y11 - y01) * tx;
      n   = a0 * one + (a1 - a0) * tz + (longint'(1) << (2 * FRAC - 1));
      res = n >>> (2 * FRAC);
      r.plateau = 1'b0;
    end

    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    r.height = res[OUT_W-1:0];
    return r;
  endfunction

  // Heights come either from the full range or from a band narrower than the threshold,
  // so that both cliffs and smooth cells turn up.
  task automatic choose_height_band();
    band_w  = (cliff_thr == 0) ? 1 : int'(cliff_thr);
    band_lo = -16 + int'($urandom_range(0, 32 - band_w));
  endtask

  function automatic logic signed [HT_W-1:0] pick_height();
    if ($urandom_range(0, 3) == 0) return HT_W'($urandom);
    return HT_W'(band_lo + int'($urandom_range(0, band_w - 1)));
  endfunction

  // Mostly inside the grid, sometimes on grid points, at the extremes or anywhere.
  function automatic logic signed [POS_W-1:0] pick_position(int size);
    case ($urandom_range(0, 9))
      0: return POS_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return '0;
          default: return POS_W'(size * (1 << FRAC) - 1);
        endcase
      end
      2: return POS_W'($urandom_range(0, size - 1) << FRAC);
      default: return POS_W'($urandom_range(0, size * (1 << FRAC) - 1));
    endcase
  endfunction

  task automatic note_failure(string msg);
    if (error_count < MAX_REPORTS) $display("%s", msg);
    error_count++;
  endtask

  // Sends one request and updates the shadow state at the edge that takes it.
  task automatic send_request(hbs_kind_t kind, logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cz,
                              logic signed [HT_W-1:0] ht, logic signed [POS_W-1:0] px,
                              logic signed [POS_W-1:0] pz);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_kind        <= kind;
    in_cell_x      <= cx;
    in_cell_z      <= cz;
    in_cell_height <= ht;
    in_pos_x       <= px;
    in_pos_z       <= pz;
    do @(posedge clk); while (busy);
    sent_items++;
    if (kind == KIND_WRITE) begin
      if (cx < GRID_W && cz < GRID_D) begin
        grid_heights[cz * GRID_W + cx] = ht;
        cell_loaded[cz * GRID_W + cx]  = 1'b1;
      end
    end else begin
      expected_heights.push_back(predict_height(px, pz));
    end
  endtask

  task automatic write_cell(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cz,
                            logic signed [HT_W-1:0] ht);
    send_request(KIND_WRITE, cx, cz, ht, POS_W'($urandom), POS_W'($urandom));
  endtask

  // Loads any corner that has never been written, then samples.
  task automatic sample_at(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
    longint x0, z0;
    x0 = base_cell(px, GRID_W);
    z0 = base_cell(pz, GRID_D);
    for (int dz = 0; dz < 2; dz++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!cell_loaded[(z0 + dz) * GRID_W + x0 + dx])
          write_cell(CELL_W'(x0 + dx), CELL_W'(z0 + dz), pick_height());
      end
    end
    send_request(KIND_SAMPLE, CELL_W'($urandom), CELL_W'($urandom), HT_W'($urandom), px, pz);
  endtask

  // Waits until every result is in and the back end has had time to finish any write.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic set_config(logic [CFG_DATA_W-1:0] thr_data,
                            logic [CFG_DATA_W-1:0] scale_data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CLIFF_THRESHOLD;
    cfg_data  <= thr_data;
    do @(posedge clk); while (!cfg_ready);
    cliff_thr = thr_data[THR_W-1:0];
    cfg_index <= CFG_HEIGHT_SCALE;
    cfg_data  <= scale_data;
    do @(posedge clk); while (!cfg_ready);
    height_scale = scale_data[SCALE_W-1:0];
    cfg_valid <= 1'b0;
    choose_height_band();
  endtask

  // Smooth cell under the reset register values, sampled inside and on a corner.
  task automatic test_smooth_blend();
    write_cell(0, 0, 0);
    write_cell(1, 0, 3);
    write_cell(0, 1, -2);
    write_cell(1, 1, 1);
    sample_at(16'sd128, 16'sd128);
    sample_at(16'sd0, 16'sd0);
    sample_at(16'sd255, 16'sd255);
  endtask

  // A full-range step gives a plateau; a threshold of zero makes every sample one.
  task automatic test_cliff_detection();
    write_cell(10, 10, 15);
    write_cell(11, 10, -16);
    write_cell(10, 11, 0);
    write_cell(11, 11, 0);
    sample_at(16'sd2624, 16'sd2752);
    set_config(0, SCALE_RESET);
    sample_at(16'sd128, 16'sd128);
  endtask

  // Scale of zero zeroes everything; full scale on a plateau and on a smooth cell.
  task automatic test_scale_extremes();
    set_config(31, 0);
    sample_at(16'sd128, 16'sd128);
    set_config(31, 16'hFFFF);
    sample_at(16'sd2624, 16'sd2752);
    sample_at(16'sd128, 16'sd128);
  endtask

  // Far extrapolation from an edge cell drives the result into both saturation limits.
  task automatic test_extrapolation_saturation();
    write_cell(0, 62, -15);
    write_cell(1, 62, 15);
    write_cell(0, 63, 15);
    write_cell(1, 63, -15);
    sample_at(16'sh8000, 16'sh7FFF);
    write_cell(0, 62, 15);
    write_cell(1, 62, -15);
    write_cell(0, 63, -15);
    write_cell(1, 63, 15);
    sample_at(16'sh8000, 16'sh7FFF);
  endtask

  // Mixed writes and samples over several register settings.
  task automatic test_random_traffic();
    int phase_end;
    logic [CFG_DATA_W-1:0] thr_data;
    logic [CFG_DATA_W-1:0] scale_data;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          thr_data   = 31;
          scale_data = 16'hFFFF;
        end
        1: begin
          thr_data   = 1;
          scale_data = 1;
        end
        3: begin
          thr_data   = THR_RESET;
          scale_data = SCALE_RESET;
        end
        default: begin
          // Bits above the threshold field are don't-care and are randomised too.
          thr_data = CFG_DATA_W'($urandom);
          thr_data[THR_W-1:0] = THR_W'($urandom_range(1, 31));
          scale_data = CFG_DATA_W'($urandom);
        end
      endcase
      set_config(thr_data, scale_data);
      phase_end = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 4) < 2)
          write_cell(CELL_W'($urandom), CELL_W'($urandom), pick_height());
        else
          sample_at(pick_position(GRID_W), pick_position(GRID_D));
      end
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin : check_results
    height_result_t want;
    if (rst_n && out_valid) begin
      if (expected_heights.size() == 0) begin
        note_failure($sformatf("unexpected result: height %0d plateau %0b",
                               out_height, out_plateau));
      end else begin
        want = expected_heights.pop_front();
        if (out_height !== want.height || out_plateau !== want.plateau)
          note_failure($sformatf("mismatch: expected height %0d plateau %0b, got %0d %0b",
                                 want.height, want.plateau, out_height, out_plateau));
      end
    end
  end

  // Stimulus sequence.
  initial begin
    cliff_thr    = THR_RESET;
    height_scale = SCALE_RESET;
    choose_height_band();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_smooth_blend();
    test_cliff_detection();
    test_scale_extremes();
    test_extrapolation_saturation();
    test_random_traffic();
    wait_idle();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
